FILE: hw/rtl/sprite_tile_blitter_assert.svh
// ---------------------------------------------------------------------------
// sprite tile blitter assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ---------------------------------------------------------------------------
`ifndef SPRITE_TILE_BLITTER_ASSERT_SVH
`define SPRITE_TILE_BLITTER_ASSERT_SVH

// same-cycle implication
`define STB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define STB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// condition that must never hold
`define STB_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

`endif

FILE: hw/rtl/stb_pkg.sv
// ---------------------------------------------------------------------------
// stb_pkg
// types, codes and constants shared by the sprite tile blitter modules
// ---------------------------------------------------------------------------
`default_nettype none

package stb_pkg;

  localparam int COLOR_BITS_DEF = 16;
  localparam int DIM            = 8;
  localparam int POS_BITS       = 3;
  localparam int IDX_BITS       = 6;
  localparam int OUT_COLOR_BITS = 16;
  localparam int IN_DATA_BITS   = 72;
  localparam int OUT_DATA_BITS  = 24;

  localparam logic [1:0] OP_LOAD_TILE   = 2'd0;
  localparam logic [1:0] OP_LOAD_SPRITE = 2'd1;
  localparam logic [1:0] OP_BLIT        = 2'd2;
  localparam logic [1:0] OP_READ        = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BLIT,
    ST_DONE,
    ST_READ
  } state_t;

  // clip of one axis: first destination position, first source position, span
  typedef struct packed {
    logic                ok;
    logic [POS_BITS-1:0] dst0;
    logic [POS_BITS-1:0] src0;
    logic [POS_BITS:0]   cnt;
  } clip_t;

endpackage

`default_nettype wire

FILE: hw/rtl/stb_clip.sv
// ---------------------------------------------------------------------------
// stb_clip
// one-axis clip of an 8-wide sprite span against an 8-wide tile span
// ---------------------------------------------------------------------------
`default_nettype none

module stb_clip
  import stb_pkg::*;
#(
  parameter int W = 16
) (
  input  wire logic [W-1:0] a1,
  input  wire logic [W-1:0] t1,
  output clip_t             clip
);

  logic [W-1:0] a2;
  logic [W-1:0] t2;
  logic         lead_in;
  logic         trail_in;

  // both far edges wrap at the axis width
  assign a2 = a1 + W'(7);
  assign t2 = t1 + W'(7);

  assign lead_in  = (a1 >= t1) && (a1 <= t2);
  assign trail_in = (a2 >= t1) && (a2 <= t2);

  always_comb begin
    clip = '0;
    if (lead_in) begin
      clip.ok   = 1'b1;
      clip.dst0 = a1[POS_BITS-1:0];
      clip.src0 = '0;
      clip.cnt  = (POS_BITS+1)'(DIM) - {1'b0, a1[POS_BITS-1:0]};
    end else if (trail_in) begin
      clip.ok   = 1'b1;
      clip.dst0 = '0;
      clip.src0 = POS_BITS'(DIM - 1) - a2[POS_BITS-1:0];
      clip.cnt  = {1'b0, a2[POS_BITS-1:0]} + (POS_BITS+1)'(1);
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/sprite_tile_blitter.sv
// ---------------------------------------------------------------------------
// sprite_tile_blitter
// 8x8 sprite blit onto an 8x8 tile with clipping and a transparent key
// ---------------------------------------------------------------------------
// usage:
//   s_* takes one command word per handshake; s_tuser carries the opcode
//   (load tile pixel, load sprite pixel, blit, read tile).
//   m_* returns result words; m_tlast marks the final word of a run.
//   loads give no word.
//   a blit walks n columns, n being the clipped column count (0..8):
//   one sprite column is read per cycle from the sprite memory and the
//   non-transparent rows are written into the tile column the next cycle.
//   it returns one word with the drawn flag.
//   a readout returns 64 words, one per cycle while the receiver takes
//   them, paced by the single tile memory read port.
//   a finished word waits in the output register while the next command
//   is taken; a stalled receiver holds the readout walk and the blit
//   result, never dropping a word.
//   reset clears control state only; store contents are undefined until
//   written, there is no clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none

module sprite_tile_blitter
  import stb_pkg::*;
#(
  parameter int COLOR_BITS = COLOR_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     s_tvalid,
  output      logic                     s_tready,
  // pixel_index, pixel_color, tile_x, tile_y, sprite_x, sprite_y, zero pad
  input  wire logic [IN_DATA_BITS-1:0]  s_tdata,
  // opcode
  input  wire logic [1:0]               s_tuser,
  output      logic                     m_tvalid,
  input  wire logic                     m_tready,
  // out_color, out_index, drawn, zero pad
  output      logic [OUT_DATA_BITS-1:0] m_tdata,
  output      logic                     m_tlast
);

  `include "sprite_tile_blitter_assert.svh"

  localparam int WIDE_BITS = (COLOR_BITS > OUT_COLOR_BITS) ? COLOR_BITS : OUT_COLOR_BITS;

  // input fields
  logic [1:0]          opcode;
  logic [IDX_BITS-1:0] pixel_index;
  logic [15:0]         pixel_color;
  logic [15:0]         tile_x;
  logic [7:0]          tile_y;
  logic [15:0]         sprite_x;
  logic [7:0]          sprite_y;

  assign opcode      = s_tuser;
  assign pixel_index = s_tdata[5:0];
  assign pixel_color = s_tdata[21:6];
  assign tile_x      = s_tdata[37:22];
  assign tile_y      = s_tdata[45:38];
  assign sprite_x    = s_tdata[61:46];
  assign sprite_y    = s_tdata[69:62];

  // memories, column-major: [column][row]
  logic [COLOR_BITS-1:0] tile_mem   [DIM][DIM];
  logic [COLOR_BITS-1:0] sprite_mem [DIM][DIM];

  state_t state;
  state_t state_next;

  logic accept;
  logic out_free;
  logic blit_issue;
  logic rd_issue;
  logic rd_load;
  logic res_load;

  clip_t clip_x;
  clip_t clip_y;

  // blit walk
  logic                drawn_res;
  logic [POS_BITS-1:0] dx;
  logic [POS_BITS-1:0] sx;
  logic [POS_BITS:0]   cols_left;
  logic [POS_BITS-1:0] dy0;
  logic [POS_BITS-1:0] sy0;
  logic [POS_BITS:0]   cy;
  logic                wb_valid;
  logic [POS_BITS-1:0] wb_col;
  logic [COLOR_BITS-1:0] sp_col [DIM];

  // readout walk
  logic [IDX_BITS-1:0] rd_cnt;
  logic                rd_valid;
  logic [IDX_BITS-1:0] rd_idx;
  logic [COLOR_BITS-1:0] tl_col [DIM];

  // tile write port
  logic [DIM-1:0]        tile_we;
  logic [POS_BITS-1:0]   tile_waddr;
  logic [COLOR_BITS-1:0] tile_wdata [DIM];

  logic [POS_BITS-1:0]   lane_rel [DIM];
  logic [POS_BITS-1:0]   lane_src [DIM];
  logic [DIM-1:0]        lane_hit;

  logic [WIDE_BITS-1:0]  in_color_wide;
  logic [WIDE_BITS-1:0]  out_color_wide;
  logic [COLOR_BITS-1:0] wr_color;
  logic [OUT_COLOR_BITS-1:0] rd_color;

  // output register
  logic [OUT_COLOR_BITS-1:0] out_color;
  logic [IDX_BITS-1:0]       out_index;
  logic                      drawn;
  logic                      last;

  stb_clip #(.W(16)) u_clip_x (
    .a1   (sprite_x),
    .t1   (tile_x),
    .clip (clip_x)
  );

  // tile top with the low three bits dropped
  stb_clip #(.W(8)) u_clip_y (
    .a1   (sprite_y),
    .t1   ({tile_y[7:POS_BITS], POS_BITS'(0)}),
    .clip (clip_y)
  );

  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign rd_load  = rd_valid && out_free;

  assign in_color_wide  = WIDE_BITS'(pixel_color);
  assign wr_color       = in_color_wide[COLOR_BITS-1:0];
  assign out_color_wide = WIDE_BITS'(tl_col[rd_idx[POS_BITS-1:0]]);
  assign rd_color       = out_color_wide[OUT_COLOR_BITS-1:0];

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (opcode)
            OP_BLIT: state_next = (clip_x.ok && clip_y.ok) ? ST_BLIT : ST_DONE;
            OP_READ: state_next = ST_READ;
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_BLIT: begin
        if (cols_left == (POS_BITS+1)'(1)) state_next = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      ST_READ: begin
        if (rd_issue && (rd_cnt == IDX_BITS'(DIM*DIM - 1))) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_tready   = 1'b0;
    blit_issue = 1'b0;
    rd_issue   = 1'b0;
    res_load   = 1'b0;
    case (state)
      ST_IDLE: s_tready   = !rd_valid;
      ST_BLIT: blit_issue = 1'b1;
      ST_DONE: res_load   = out_free;
      ST_READ: rd_issue   = !rd_valid || rd_load;
      default: s_tready   = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // row merge: destination row r takes source row sy0 + (r - dy0)
  always_comb begin
    for (int r = 0; r < DIM; r++) begin
      lane_rel[r] = POS_BITS'(r) - dy0;
      lane_src[r] = sy0 + lane_rel[r];
      lane_hit[r] = ({1'b0, lane_rel[r]} < cy) && (sp_col[lane_src[r]] != '0);
    end
  end

  always_comb begin
    tile_we    = '0;
    tile_waddr = wb_col;
    for (int r = 0; r < DIM; r++) begin
      tile_wdata[r] = sp_col[lane_src[r]];
    end
    if (accept && (opcode == OP_LOAD_TILE)) begin
      tile_waddr = pixel_index[IDX_BITS-1:POS_BITS];
      for (int r = 0; r < DIM; r++) begin
        tile_wdata[r] = wr_color;
      end
      tile_we[pixel_index[POS_BITS-1:0]] = 1'b1;
    end else if (wb_valid) begin
      tile_we = lane_hit;
    end
  end

  always_ff @(posedge clk) begin
    for (int r = 0; r < DIM; r++) begin
      if (tile_we[r]) tile_mem[tile_waddr][r] <= tile_wdata[r];
    end
    if (rd_issue) tl_col <= tile_mem[rd_cnt[IDX_BITS-1:POS_BITS]];
  end

  always_ff @(posedge clk) begin
    if (accept && (opcode == OP_LOAD_SPRITE)) begin
      sprite_mem[pixel_index[IDX_BITS-1:POS_BITS]][pixel_index[POS_BITS-1:0]] <= wr_color;
    end
    if (blit_issue) sp_col <= sprite_mem[sx];
  end

  // blit walk registers
  always_ff @(posedge clk) begin
    if (rst) begin
      wb_valid <= 1'b0;
    end else begin
      wb_valid <= blit_issue;
    end
    if (accept && (opcode == OP_BLIT)) begin
      drawn_res <= clip_x.ok && clip_y.ok;
      dx        <= clip_x.dst0;
      sx        <= clip_x.src0;
      cols_left <= clip_x.cnt;
      dy0       <= clip_y.dst0;
      sy0       <= clip_y.src0;
      cy        <= clip_y.cnt;
    end else if (blit_issue) begin
      dx        <= dx + POS_BITS'(1);
      sx        <= sx + POS_BITS'(1);
      cols_left <= cols_left - (POS_BITS+1)'(1);
    end
    if (blit_issue) wb_col <= dx;
  end

  // readout walk registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else if (rd_issue) begin
      rd_valid <= 1'b1;
    end else if (rd_load) begin
      rd_valid <= 1'b0;
    end
    if (accept && (opcode == OP_READ)) begin
      rd_cnt <= '0;
    end else if (rd_issue) begin
      rd_cnt <= rd_cnt + IDX_BITS'(1);
    end
    if (rd_issue) rd_idx <= rd_cnt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (rd_load || res_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (rd_load) begin
      out_color <= rd_color;
      out_index <= rd_idx;
      drawn     <= 1'b0;
      last      <= (rd_idx == IDX_BITS'(DIM*DIM - 1));
    end else if (res_load) begin
      out_color <= '0;
      out_index <= '0;
      drawn     <= drawn_res;
      last      <= 1'b1;
    end
  end

  assign m_tdata = {1'b0, drawn, out_index, out_color};
  assign m_tlast = last;

  `STB_NEVER(a_no_tile_write_in_read, (state == ST_READ) && (tile_we != '0), "tile written during readout")
  `STB_NEVER(a_out_collide, rd_load && res_load, "readout word and blit result collide")
  `STB_ASSERT_NOW(a_blit_cols, state == ST_BLIT, cols_left != '0, "blit walk with no columns left")
  `STB_ASSERT_NEXT(a_read_drains, rd_load && (rd_idx == IDX_BITS'(DIM*DIM - 1)), !rd_valid && (state == ST_IDLE), "readout did not end after last word")

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the sprite tile blitter: fills both pixel stores,
// runs directed and random loads, blits and tile readouts through the
// stream ports, and checks every result word against an in-bench predictor
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top
  import stb_pkg::*;
();

  localparam int CLK_HALF     = 6;
  localparam int LIMIT        = 400000;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 100;
  localparam int MAX_REPORTS  = 200;

  typedef struct {
    logic [1:0]  opcode;
    logic [5:0]  pixel_index;
    logic [15:0] pixel_color;
    logic [15:0] tile_x;
    logic [7:0]  tile_y;
    logic [15:0] sprite_x;
    logic [7:0]  sprite_y;
  } blit_cmd_t;

  typedef struct packed {
    logic [15:0] color;
    logic [5:0]  index;
    logic        drawn;
    logic        last;
  } result_word_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     s_tvalid = 1'b0;
  logic                     s_tready;
  // pixel_index, pixel_color, tile_x, tile_y, sprite_x, sprite_y, zero pad
  logic [IN_DATA_BITS-1:0]  s_tdata = '0;
  // opcode
  logic [1:0]               s_tuser = OP_LOAD_TILE;
  logic                     m_tvalid;
  logic                     m_tready = 1'b0;
  // out_color, out_index, drawn, zero pad
  logic [OUT_DATA_BITS-1:0] m_tdata;
  logic                     m_tlast;

  sprite_tile_blitter dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  blit_cmd_t    cmd_queue[$];
  result_word_t expected_words[$];
  logic [15:0]  tile_pix[64];
  logic [15:0]  sprite_pix[64];

  int n_items;
  int accepted;
  int pause_at;
  int hold_at;
  int cycles;
  int errors;
  int words_checked;
  int blits_drawn;
  int blits_missed;
  int readouts;

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  always @(posedge clk) cycles <= cycles + 1;

  initial begin
    while (cycles < LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d of %0d commands taken, %0d words pending",
             cycles, accepted, n_items, expected_words.size());
    $display("FAILED: results differ");
    $finish;
  end

  // ------------------------------------------------------------------------
  // predictor
  // ------------------------------------------------------------------------

  // pick the clip on one axis from whichever sprite edge lands in the window
  function automatic bit clip_axis_span(input logic [15:0] lead_edge,
                                        input logic [15:0] trail_edge,
                                        input logic [15:0] win_lo,
                                        input logic [15:0] win_hi,
                                        output logic [2:0] dst0,
                                        output logic [2:0] src0,
                                        output logic [3:0] span);
    dst0 = 3'd0;
    src0 = 3'd0;
    span = 4'd0;
    if (lead_edge >= win_lo && lead_edge <= win_hi) begin
      dst0 = lead_edge[2:0];
      span = 4'd8 - {1'b0, lead_edge[2:0]};
      return 1'b1;
    end
    if (trail_edge >= win_lo && trail_edge <= win_hi) begin
      src0 = 3'd7 - trail_edge[2:0];
      span = {1'b0, trail_edge[2:0]} + 4'd1;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic predict_command(input blit_cmd_t c);
    logic [15:0]  tile_right;
    logic [15:0]  sprite_right;
    logic [7:0]   tile_top;
    logic [7:0]   sprite_bottom;
    logic [2:0]   dx0, sx0, dy0, sy0;
    logic [3:0]   cols, rows;
    bit           hit;
    int           src, dst;
    result_word_t w;
    case (c.opcode)
      OP_LOAD_TILE:   tile_pix[c.pixel_index] = c.pixel_color;
      OP_LOAD_SPRITE: sprite_pix[c.pixel_index] = c.pixel_color;
      OP_READ: begin
        for (int i = 0; i < 64; i++) begin
          w = {tile_pix[i], 6'(i), 1'b0, i == 63};
          expected_words.push_back(w);
        end
        readouts++;
      end
      default: begin
        tile_right    = c.tile_x + 16'd7;
        sprite_right  = c.sprite_x + 16'd7;
        tile_top      = {c.tile_y[7:3], 3'b000};
        sprite_bottom = c.sprite_y + 8'd7;
        hit = clip_axis_span(c.sprite_x, sprite_right, c.tile_x, tile_right,
                             dx0, sx0, cols);
        if (hit) begin
          hit = clip_axis_span({8'd0, c.sprite_y}, {8'd0, sprite_bottom},
                               {8'd0, tile_top}, {8'd0, tile_top} + 16'd7,
                               dy0, sy0, rows);
        end
        if (hit) begin
          for (int i = 0; i < cols; i++) begin
            for (int j = 0; j < rows; j++) begin
              src = ((sx0 + i) & 7) * 8 + ((sy0 + j) & 7);
              dst = ((dx0 + i) & 7) * 8 + ((dy0 + j) & 7);
              // colour zero is the transparent key
              if (sprite_pix[src] != 16'd0) tile_pix[dst] = sprite_pix[src];
            end
          end
          blits_drawn++;
        end else begin
          blits_missed++;
        end
        w = {16'd0, 6'd0, hit, 1'b1};
        expected_words.push_back(w);
      end
    endcase
  endtask

  // ------------------------------------------------------------------------
  // stimulus
  // ------------------------------------------------------------------------

  task automatic push_cmd(input logic [1:0] op, input logic [5:0] idx,
                          input logic [15:0] color, input logic [15:0] tx,
                          input logic [7:0] ty, input logic [15:0] sx,
                          input logic [7:0] sy);
    blit_cmd_t c;
    c.opcode      = op;
    c.pixel_index = idx;
    c.pixel_color = color;
    c.tile_x      = tx;
    c.tile_y      = ty;
    c.sprite_x    = sx;
    c.sprite_y    = sy;
    cmd_queue.push_back(c);
  endtask

  task automatic push_blit(input logic [15:0] tx, input logic [7:0] ty,
                           input logic [15:0] sx, input logic [7:0] sy);
    push_cmd(OP_BLIT, 6'($urandom), 16'($urandom), tx, ty, sx, sy);
  endtask

  // sprite mostly placed around the tile so the clip paths get exercised
  task automatic push_random_blit();
    logic [15:0] tx, sx;
    logic [7:0]  ty, sy;
    int          dx, dy;
    tx = 16'($urandom);
    if ($urandom_range(9) != 0) tx[2:0] = 3'd0;
    ty = 8'($urandom);
    dx = int'($urandom_range(20)) - 10;
    dy = int'($urandom_range(20)) - 10;
    sx = tx + dx[15:0];
    sy = {ty[7:3], 3'b000} + dy[7:0];
    if ($urandom_range(9) == 0) sx = 16'($urandom);
    if ($urandom_range(9) == 0) sy = 8'($urandom);
    push_blit(tx, ty, sx, sy);
  endtask

  task automatic build_stimulus();
    logic [15:0] color;
    int          pick;
    // every entry written before any blit or readout touches the stores
    for (int i = 0; i < 64; i++) begin
      color = (i == 0) ? 16'h0000 : (i == 63) ? 16'hffff : 16'($urandom);
      push_cmd(OP_LOAD_TILE, 6'(i), color, 16'($urandom), 8'($urandom),
               16'($urandom), 8'($urandom));
    end
    for (int i = 0; i < 64; i++) begin
      color = ($urandom_range(3) == 0) ? 16'h0000 : 16'($urandom);
      if (i == 5) color = 16'hffff;
      push_cmd(OP_LOAD_SPRITE, 6'(i), color, 16'($urandom), 8'($urandom),
               16'($urandom), 8'($urandom));
    end

    push_cmd(OP_READ, 6'h3f, 16'hffff, 16'hffff, 8'hff, 16'hffff, 8'hff);
    push_blit(16'h1000, 8'h10, 16'h1000, 8'h10);   // full overlap
    push_cmd(OP_READ, 6'h00, 16'h0000, 16'h0000, 8'h00, 16'h0000, 8'h00);
    push_blit(16'h2000, 8'h20, 16'h2003, 8'h25);   // left and top edges inside
    push_blit(16'h2000, 8'h20, 16'h1ffd, 8'h1e);   // right and bottom edges inside
    push_blit(16'h3000, 8'h40, 16'h3014, 8'h40);   // misses horizontally
    push_blit(16'h3000, 8'h40, 16'h3000, 8'h49);   // misses vertically
    push_blit(16'hfffc, 8'h00, 16'hfffd, 8'h00);   // tile right edge wraps
    push_blit(16'hfff8, 8'h08, 16'hfffc, 8'h08);   // sprite right edge wraps
    push_blit(16'hfff8, 8'h08, 16'hfff5, 8'h0a);
    push_blit(16'h0000, 8'h00, 16'hfffe, 8'h00);   // wrapped right edge hits tile 0
    push_blit(16'h0000, 8'h00, 16'h0002, 8'hfc);   // sprite bottom wraps
    push_blit(16'h4000, 8'hff, 16'h4001, 8'hfa);   // bottom tile row
    push_blit(16'h1003, 8'h37, 16'h1005, 8'h33);   // unaligned tile_x, tile_y low bits
    push_blit(16'hffff, 8'hff, 16'hffff, 8'hff);
    push_blit(16'h0000, 8'h00, 16'h0000, 8'h00);
    push_cmd(OP_LOAD_TILE, 6'h3f, 16'hffff, 16'h0000, 8'h00, 16'h0000, 8'h00);
    push_cmd(OP_LOAD_SPRITE, 6'h00, 16'h0000, 16'hffff, 8'hff, 16'hffff, 8'hff);
    push_cmd(OP_LOAD_SPRITE, 6'h3f, 16'hffff, 16'h0000, 8'h00, 16'h0000, 8'h00);
    push_blit(16'h5000, 8'h50, 16'h5000, 8'h50);
    push_cmd(OP_READ, 6'($urandom), 16'($urandom), 16'($urandom), 8'($urandom),
             16'($urandom), 8'($urandom));

    for (int k = 0; k < 262; k++) begin
      pick = $urandom_range(99);
      if (pick < 35) begin
        push_cmd(OP_LOAD_TILE, 6'($urandom), 16'($urandom), 16'($urandom),
                 8'($urandom), 16'($urandom), 8'($urandom));
      end else if (pick < 65) begin
        color = ($urandom_range(3) == 0) ? 16'h0000 : 16'($urandom);
        push_cmd(OP_LOAD_SPRITE, 6'($urandom), color, 16'($urandom),
                 8'($urandom), 16'($urandom), 8'($urandom));
      end else if (pick < 93) begin
        push_random_blit();
      end else begin
        push_cmd(OP_READ, 6'($urandom), 16'($urandom), 16'($urandom),
                 8'($urandom), 16'($urandom), 8'($urandom));
      end
    end
  endtask

  // ------------------------------------------------------------------------
  // idle rates: receiver-heavy gaps, then sender-heavy, then none
  // ------------------------------------------------------------------------

  function int run_phase();
    if (accepted < n_items / 3) return 0;
    if (accepted < (2 * n_items) / 3) return 1;
    return 2;
  endfunction

  function int sender_idle_pct();
    case (run_phase())
      0:       return 37;
      1:       return 63;
      default: return 0;
    endcase
  endfunction

  function int receiver_idle_pct();
    case (run_phase())
      0:       return 63;
      1:       return 37;
      default: return 0;
    endcase
  endfunction

  // ------------------------------------------------------------------------
  // driver
  // ------------------------------------------------------------------------

  blit_cmd_t drv_cmd;
  logic      drv_fire;
  logic      drv_offer;
  logic      pause_done = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      drv_fire = s_tvalid && s_tready;
      if (drv_fire) begin
        predict_command(drv_cmd);
        accepted++;
      end
      // a word on offer stays until taken
      if (!s_tvalid || drv_fire) begin
        drv_offer = cmd_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct();
        // one pause mid-run until the block has drained completely
        if (!pause_done && accepted >= pause_at) begin
          if (expected_words.size() == 0) pause_done = 1'b1;
          drv_offer = 1'b0;
        end
        if (drv_offer) begin
          drv_cmd = cmd_queue.pop_front();
          s_tdata <= {2'b00, drv_cmd.sprite_y, drv_cmd.sprite_x, drv_cmd.tile_y,
                      drv_cmd.tile_x, drv_cmd.pixel_color, drv_cmd.pixel_index};
          s_tuser <= drv_cmd.opcode;
        end
        s_tvalid <= drv_offer;
      end
    end
  end

  // ------------------------------------------------------------------------
  // monitor
  // ------------------------------------------------------------------------

  result_word_t got_word;
  result_word_t want_word;
  logic         mon_ready;
  logic         hold_done = 1'b0;
  int           hold_left;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got_word = {m_tdata[15:0], m_tdata[21:16], m_tdata[22], m_tlast};
        if (expected_words.size() == 0) begin
          if (errors < MAX_REPORTS)
            $display("%0t: unexpected word color=%h index=%0d drawn=%b last=%b",
                     $time, got_word.color, got_word.index, got_word.drawn,
                     got_word.last);
          errors++;
        end else begin
          want_word = expected_words.pop_front();
          if (got_word.color !== want_word.color || got_word.index !== want_word.index ||
              got_word.drawn !== want_word.drawn || got_word.last !== want_word.last) begin
            if (errors < MAX_REPORTS)
              $display({"%0t: mismatch expected color=%h index=%0d drawn=%b last=%b,",
                        " got color=%h index=%0d drawn=%b last=%b"},
                       $time, want_word.color, want_word.index, want_word.drawn,
                       want_word.last, got_word.color, got_word.index,
                       got_word.drawn, got_word.last);
            errors++;
          end
          words_checked++;
        end
      end
      // one long back-pressure stretch so the block fills and stalls its input
      if (hold_left != 0) begin
        hold_left--;
        mon_ready = 1'b0;
      end else if (!hold_done && accepted >= hold_at) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        mon_ready = 1'b0;
      end else begin
        mon_ready = $urandom_range(99) >= receiver_idle_pct();
      end
      m_tready <= mon_ready;
    end
  end

  // ------------------------------------------------------------------------
  // run control
  // ------------------------------------------------------------------------

  initial begin
    build_stimulus();
    n_items  = cmd_queue.size();
    pause_at = n_items / 2;
    hold_at  = (3 * n_items) / 4;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    while (!(accepted == n_items && expected_words.size() == 0)) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_words.size() != 0) begin
      $display("%0t: %0d expected words never arrived", $time, expected_words.size());
      errors++;
    end
    $display("ran %0d commands: %0d blits drawn, %0d blits clipped away, %0d tile readouts",
             accepted, blits_drawn, blits_missed, readouts);
    $display("checked %0d result words in %0d cycles, %0d mismatches",
             words_checked, cycles, errors);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
